[rtl/core/i2p_pkg.sv]
package i2p_pkg;

  // sizing
  localparam int STACK_DEPTH  = 16;
  localparam int OPERAND_BITS = 16;
  localparam int KIND_W       = 4;
  localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W        = $clog2(STACK_DEPTH);
  localparam int PRIO_W       = 4;

  // token codes
  localparam logic [KIND_W-1:0] K_OPERAND = 4'd0;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 4'd1;
  localparam logic [KIND_W-1:0] K_POW     = 4'd2;
  localparam logic [KIND_W-1:0] K_MINUS   = 4'd3;
  localparam logic [KIND_W-1:0] K_MUL     = 4'd4;
  localparam logic [KIND_W-1:0] K_DIV     = 4'd5;
  localparam logic [KIND_W-1:0] K_PLUS    = 4'd6;
  localparam logic [KIND_W-1:0] K_OPEN    = 4'd7;
  localparam logic [KIND_W-1:0] K_CLOSE   = 4'd8;
  localparam logic [KIND_W-1:0] K_END     = 4'd9;
  localparam logic [KIND_W-1:0] K_NEG     = 4'd10;

  // status codes
  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_OVERFLOW       = 2'd1;
  localparam logic [1:0] ST_UNMATCHED_CLOSE = 2'd2;
  localparam logic [1:0] ST_UNMATCHED_OPEN = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]       token_kind;
    logic [OPERAND_BITS-1:0] operand_id;
  } in_tok_t;

  typedef struct packed {
    logic [KIND_W-1:0]       out_kind;
    logic [OPERAND_BITS-1:0] out_operand_id;
    logic [1:0]              status;
    logic                    last_of_run;
  } out_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    CL_OPERAND,
    CL_OPERATOR,
    CL_CLOSE,
    CL_END
  } tok_class_e;

  typedef enum logic [1:0] {
    RS_OPERAND,
    RS_TOP,
    RS_CLOSE_ERR,
    RS_OVERFLOW
  } res_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     pop;
    logic     push;
    res_sel_e res_sel;
    logic     load_pend;
    logic     clr_pend;
    logic     out_load;
    logic     out_from_pend;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    tok_class_e tok_class;
    logic       empty;
    logic       full;
    logic       top_open;
    logic       top_pops;
    logic       pend_valid;
    logic       out_free;
  } dp_sts_t;

  // priority of an operator sitting on the stack
  function automatic logic signed [PRIO_W-1:0] in_stack_prio(input logic [KIND_W-1:0] k);
    logic signed [PRIO_W-1:0] p;
    case (k)
      K_ASSIGN:       p = -4'sd1;
      K_POW, K_NEG:   p = 4'sd3;
      K_MUL, K_DIV:   p = 4'sd2;
      K_MINUS, K_PLUS: p = 4'sd1;
      K_OPEN:         p = 4'sd0;
      default:        p = -4'sd2;
    endcase
    return p;
  endfunction

  // priority of an arriving operator
  function automatic logic signed [PRIO_W-1:0] incoming_prio(input logic [KIND_W-1:0] k);
    logic signed [PRIO_W-1:0] p;
    case (k)
      K_ASSIGN:       p = -4'sd1;
      K_POW, K_NEG:   p = 4'sd4;
      K_MUL, K_DIV:   p = 4'sd2;
      K_MINUS, K_PLUS: p = 4'sd1;
      K_OPEN:         p = 4'sd5;
      default:        p = -4'sd2;
    endcase
    return p;
  endfunction

  function automatic tok_class_e classify(input logic [KIND_W-1:0] k);
    tok_class_e c;
    case (k)
      K_END:   c = CL_END;
      K_CLOSE: c = CL_CLOSE;
      K_ASSIGN, K_POW, K_MINUS, K_MUL, K_DIV, K_PLUS, K_OPEN, K_NEG: c = CL_OPERATOR;
      default: c = CL_OPERAND;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/i2p_datapath.sv]
module i2p_datapath import i2p_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_tok_t  in_tok_i,
  input  logic     out_ready_i,
  output out_res_t out_res_o,
  output logic     out_valid_o,
  input  dp_cmd_t  cmd_i,
  output dp_sts_t  sts_o
);

  logic [KIND_W-1:0]       kind_q;
  logic [OPERAND_BITS-1:0] id_q;
  logic                    lwo_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [KIND_W-1:0]       stack_q [STACK_DEPTH];
  out_res_t                pend_q;
  logic                    pend_valid_q, pend_valid_d;
  out_res_t                out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic [KIND_W-1:0] in_kind;
  logic [CNT_W-1:0]  count_m1;
  logic [IDX_W-1:0]  top_idx;
  logic [KIND_W-1:0] top_kind;
  out_res_t          res;

  // minus after an operator is unary
  assign in_kind  = (in_tok_i.token_kind == K_MINUS && lwo_q) ? K_NEG : in_tok_i.token_kind;
  assign count_m1 = count_q - CNT_W'(1);
  assign top_idx  = count_m1[IDX_W-1:0];
  assign top_kind = stack_q[top_idx];

  always_comb begin
    res = '0;
    case (cmd_i.res_sel)
      RS_OPERAND: begin
        res.out_kind       = K_OPERAND;
        res.out_operand_id = id_q;
      end
      RS_TOP: begin
        res.out_kind = top_kind;
        res.status   = (top_kind == K_OPEN) ? ST_UNMATCHED_OPEN : ST_OK;
      end
      RS_CLOSE_ERR: begin
        res.out_kind = K_CLOSE;
        res.status   = ST_UNMATCHED_CLOSE;
      end
      RS_OVERFLOW: begin
        res.out_kind = kind_q;
        res.status   = ST_OVERFLOW;
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    sts_o.tok_class  = classify(kind_q);
    sts_o.empty      = (count_q == '0);
    sts_o.full       = (count_q == CNT_W'(STACK_DEPTH));
    sts_o.top_open   = (top_kind == K_OPEN);
    sts_o.top_pops   = (top_kind != K_OPEN) &&
                       (in_stack_prio(top_kind) >= incoming_prio(kind_q));
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.pop) begin
      count_d = count_m1;
    end else if (cmd_i.push) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.load_pend) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.clr_pend) begin
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_d             = cmd_i.out_from_pend ? pend_q : res;
    out_d.last_of_run = cmd_i.out_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      lwo_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cmd_i.load_in) begin
        lwo_q <= (classify(in_kind) == CL_OPERATOR);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q <= in_kind;
      id_q   <= in_tok_i.operand_id;
    end
    if (cmd_i.push) begin
      stack_q[count_q[IDX_W-1:0]] <= kind_q;
    end
    if (cmd_i.load_pend) begin
      pend_q <= res;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_res_o   = out_q;
  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/i2p_ctrl.sv]
module i2p_ctrl import i2p_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e   state_q, state_d;
  logic     gen, fin, pop, push, need_out, go;
  res_sel_e sel;

  // what one step of the current token would do
  always_comb begin
    gen  = 1'b0;
    fin  = 1'b0;
    pop  = 1'b0;
    push = 1'b0;
    sel  = RS_OPERAND;
    case (sts_i.tok_class)
      CL_OPERAND: begin
        gen = 1'b1;
        fin = 1'b1;
      end
      CL_END: begin
        if (sts_i.empty) begin
          fin = 1'b1;
        end else begin
          gen = 1'b1;
          sel = RS_TOP;
          pop = 1'b1;
        end
      end
      CL_CLOSE: begin
        if (sts_i.empty) begin
          gen = 1'b1;
          sel = RS_CLOSE_ERR;
          fin = 1'b1;
        end else if (sts_i.top_open) begin
          pop = 1'b1;
          fin = 1'b1;
        end else begin
          gen = 1'b1;
          sel = RS_TOP;
          pop = 1'b1;
        end
      end
      CL_OPERATOR: begin
        if (!sts_i.empty && sts_i.top_pops) begin
          gen = 1'b1;
          sel = RS_TOP;
          pop = 1'b1;
        end else if (sts_i.full) begin
          gen = 1'b1;
          sel = RS_OVERFLOW;
          fin = 1'b1;
        end else begin
          push = 1'b1;
          fin  = 1'b1;
        end
      end
      default: fin = 1'b1;
    endcase
  end

  assign need_out = (gen && (sts_i.pend_valid || fin)) || (!gen && fin && sts_i.pend_valid);
  assign go       = !need_out || sts_i.out_free;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res_sel = sel;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        if (go) begin
          cmd_o.pop  = pop;
          cmd_o.push = push;
          if (gen) begin
            if (sts_i.pend_valid) begin
              cmd_o.out_load      = 1'b1;
              cmd_o.out_from_pend = 1'b1;
              cmd_o.load_pend     = 1'b1;
              if (fin) begin
                state_d = ST_FLUSH;
              end
            end else if (fin) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              state_d        = ST_IDLE;
            end else begin
              cmd_o.load_pend = 1'b1;
            end
          end else if (fin) begin
            if (sts_i.pend_valid) begin
              cmd_o.out_load      = 1'b1;
              cmd_o.out_from_pend = 1'b1;
              cmd_o.out_last      = 1'b1;
              cmd_o.clr_pend      = 1'b1;
            end
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load      = 1'b1;
          cmd_o.out_from_pend = 1'b1;
          cmd_o.out_last      = 1'b1;
          cmd_o.clr_pend      = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/infix_to_postfix_converter_unit.sv]
// result path: an accepted operand is held in the token register, then moves to the output
// register when free; per token: accept, one pop per stack entry, then a finish step (push,
//   matched open, empty-stack check, operand, overflow or stray close); a stray close after
//   pops sends its held result in one more step; output stalls hold any of these steps
// pops run one stack entry per cycle unless the output stalls; tokens are taken only in idle
// reset: sequencer idle; stack count, operator flag, pending and output valid cleared
module infix_to_postfix_converter_unit import i2p_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_tok_t  in_tok_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_res_t out_res_o
);

  // command and status bundles between the sequencer and the stack datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: one step of the shunting-yard loop per cycle unless the output stalls
  i2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: token register, operator stack, one pending result held back so that
  // the final result of a run can be marked, and the output register
  i2p_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tok_i    (in_tok_i),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o),
    .out_valid_o (out_valid_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // a new transaction only starts with nothing held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.pend_valid)
    else $error("pending result left over at token accept");

  // never push onto a full stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.full)
    else $error("push onto full operator stack");

  // never pop an empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.empty)
    else $error("pop of empty operator stack");

  // output register is only reloaded when free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten while stalled");

endmodule

[tb/infix_to_postfix_converter_unit_tb.sv]
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;
  import i2p_pkg::*;

  // one row of the directed table: a token, and where it is obvious, the single result it gives
  typedef struct packed {
    in_tok_t  tok;
    logic     typed;
    out_res_t res;
  } stim_row_t;

  localparam int DIRECTED_N = 24;
  localparam int RANDOM_N   = 150;

  // directed walk: extremes of the operand, stray close, unused code, leftover open,
  // then one expression that uses every operator, a unary minus and a bracketed term
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{'{K_OPERAND, 16'h0000}, 1'b1, '{K_OPERAND, 16'h0000, ST_OK, 1'b1}},
    '{'{K_OPERAND, 16'hFFFF}, 1'b1, '{K_OPERAND, 16'hFFFF, ST_OK, 1'b1}},
    '{'{K_CLOSE,   16'hFFFF}, 1'b1, '{K_CLOSE, 16'h0000, ST_UNMATCHED_CLOSE, 1'b1}},
    '{'{4'hF,      16'h5A5A}, 1'b1, '{K_OPERAND, 16'h5A5A, ST_OK, 1'b1}},
    '{'{K_OPEN,    16'h0000}, 1'b0, '0},
    '{'{K_END,     16'h0000}, 1'b1, '{K_OPEN, 16'h0000, ST_UNMATCHED_OPEN, 1'b1}},
    '{'{K_OPERAND, 16'h0001}, 1'b0, '0},
    '{'{K_ASSIGN,  16'h0000}, 1'b0, '0},
    '{'{K_MINUS,   16'h0000}, 1'b0, '0},
    '{'{K_OPERAND, 16'h0002}, 1'b0, '0},
    '{'{K_POW,     16'h0000}, 1'b0, '0},
    '{'{K_OPERAND, 16'h0003}, 1'b0, '0},
    '{'{K_MUL,     16'h0000}, 1'b0, '0},
    '{'{K_OPEN,    16'h0000}, 1'b0, '0},
    '{'{K_OPERAND, 16'h0004}, 1'b0, '0},
    '{'{K_PLUS,    16'h0000}, 1'b0, '0},
    '{'{K_NEG,     16'h0000}, 1'b0, '0},
    '{'{K_OPERAND, 16'h0005}, 1'b0, '0},
    '{'{K_CLOSE,   16'h0000}, 1'b0, '0},
    '{'{K_DIV,     16'h0000}, 1'b0, '0},
    '{'{K_OPERAND, 16'h0006}, 1'b0, '0},
    '{'{K_MINUS,   16'h0000}, 1'b0, '0},
    '{'{K_OPERAND, 16'h0007}, 1'b0, '0},
    '{'{K_END,     16'h0000}, 1'b0, '0}
  };

  // operators that may stand between two operands
  localparam logic [KIND_W-1:0] BINARY_OPS [7] = '{
    K_ASSIGN, K_POW, K_MINUS, K_MUL, K_DIV, K_PLUS, K_NEG
  };

  // operators that always land on the stack when stacked one after another
  localparam logic [KIND_W-1:0] STACKING_OPS [4] = '{K_OPEN, K_POW, K_NEG, K_MINUS};

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  in_tok_t  in_tok_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_res_t out_res_o;

  // predicted converter state
  logic [KIND_W-1:0] op_stack [STACK_DEPTH];
  int unsigned       op_depth    = 0;
  bit                prev_was_op = 1'b0;

  out_res_t token_results [$];   // results of the latest accepted token
  out_res_t awaited_results [$]; // results still to arrive, oldest first

  int snd_idle_pct = 25;
  int rcv_idle_pct = 58;
  int tokens_sent  = 0;
  int mismatches   = 0;

  infix_to_postfix_converter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_tok_i    (in_tok_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // rank of an operator; '^', '~' and '(' rank higher when arriving than when stacked
  function automatic int op_rank(input logic [KIND_W-1:0] k, input bit arriving);
    int r;
    r = -2;
    if (k == K_ASSIGN) r = -1;
    else if (k == K_MINUS || k == K_PLUS) r = 1;
    else if (k == K_MUL || k == K_DIV) r = 2;
    else if (k == K_POW || k == K_NEG) r = arriving ? 4 : 3;
    else if (k == K_OPEN) r = arriving ? 5 : 0;
    return r;
  endfunction

  function automatic out_res_t result_of(input logic [KIND_W-1:0] k,
                                         input logic [OPERAND_BITS-1:0] id,
                                         input logic [1:0] st);
    out_res_t r;
    r.out_kind       = k;
    r.out_operand_id = id;
    r.status         = st;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  // shunting-yard step: advances the predicted stack and fills token_results
  function automatic void convert_token(input in_tok_t tok);
    logic [KIND_W-1:0] k;
    logic [KIND_W-1:0] t;
    bit                matched;
    bit                halt;
    out_res_t          r;
    k = tok.token_kind;
    token_results.delete();
    // a minus right after an operator is a sign, not a subtraction
    if (k == K_MINUS && prev_was_op) k = K_NEG;
    if (k == K_END) begin
      while (op_depth > 0) begin
        op_depth--;
        t = op_stack[op_depth];
        token_results.push_back(result_of(t, '0, (t == K_OPEN) ? ST_UNMATCHED_OPEN : ST_OK));
      end
      prev_was_op = 1'b0;
    end else if (k == K_CLOSE) begin
      matched = 1'b0;
      while (op_depth > 0 && !matched) begin
        op_depth--;
        t = op_stack[op_depth];
        if (t == K_OPEN) matched = 1'b1;
        else token_results.push_back(result_of(t, '0, ST_OK));
      end
      if (!matched) token_results.push_back(result_of(K_CLOSE, '0, ST_UNMATCHED_CLOSE));
      prev_was_op = 1'b0;
    end else if (k == K_OPERAND || k > K_NEG) begin
      // unused codes travel as operands
      token_results.push_back(result_of(K_OPERAND, tok.operand_id, ST_OK));
      prev_was_op = 1'b0;
    end else begin
      halt = 1'b0;
      while (op_depth > 0 && !halt) begin
        t = op_stack[op_depth - 1];
        if (t == K_OPEN || op_rank(t, 1'b0) < op_rank(k, 1'b1)) begin
          halt = 1'b1;
        end else begin
          op_depth--;
          token_results.push_back(result_of(t, '0, ST_OK));
        end
      end
      // a full stack drops the operator and reports it
      if (op_depth >= STACK_DEPTH) begin
        token_results.push_back(result_of(k, '0, ST_OVERFLOW));
      end else begin
        op_stack[op_depth] = k;
        op_depth++;
      end
      prev_was_op = 1'b1;
    end
    if (token_results.size() > 0) begin
      r = token_results.pop_back();
      r.last_of_run = 1'b1;
      token_results.push_back(r);
    end
  endfunction

  // offer one token from a falling edge and hold it until the transaction completes;
  // returns at the falling edge after acceptance with valid still high
  task automatic send_token(input in_tok_t tok, input bit typed = 1'b0,
                            input out_res_t typed_res = '0);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_tok_i   <= tok;
    do @(posedge clk_i); while (!in_ready_o);
    convert_token(tok);
    if (typed) awaited_results.push_back(typed_res);
    else foreach (token_results[i]) awaited_results.push_back(token_results[i]);
    tokens_sent++;
    @(negedge clk_i);
  endtask

  // token of a given kind; the id is random even where it is ignored
  task automatic send_kind(input logic [KIND_W-1:0] k);
    in_tok_t tok;
    tok.token_kind = k;
    tok.operand_id = 16'($urandom_range(65535));
    send_token(tok);
  endtask

  // operand, now and then with one of the unused codes
  task automatic send_operand();
    send_kind(($urandom_range(9) == 0) ? 4'($urandom_range(15, 11)) : K_OPERAND);
  endtask

  // receiver back-pressure, changed only at the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // result checking at the rising edge, field by field against the oldest prediction
  always @(posedge clk_i) begin
    out_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: out_kind %0d out_operand_id %0h status %0d",
               out_res_o.out_kind, out_res_o.out_operand_id, out_res_o.status);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_res_o.out_kind !== want.out_kind) begin
          $error("out_kind: expected %0d, actual %0d", want.out_kind, out_res_o.out_kind);
          mismatches++;
        end
        if (out_res_o.out_operand_id !== want.out_operand_id) begin
          $error("out_operand_id: expected %0h, actual %0h",
                 want.out_operand_id, out_res_o.out_operand_id);
          mismatches++;
        end
        if (out_res_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_res_o.status);
          mismatches++;
        end
        if (out_res_o.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b",
                 want.last_of_run, out_res_o.last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int pick;
    int n_operands;
    int open_count;
    // reset held low from the start, released at a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, with the sender at 25 % idle and the receiver at 58 %
    foreach (DIRECTED_ROWS[i]) begin
      send_token(DIRECTED_ROWS[i].tok, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end

    // random part: mostly well-formed expressions, some noise, some stack stress
    while (tokens_sent < DIRECTED_N + RANDOM_N) begin
      // idle profile swaps after a third, and goes away for the last third
      if (tokens_sent >= DIRECTED_N + 2 * RANDOM_N / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end else if (tokens_sent >= DIRECTED_N + RANDOM_N / 3) begin
        snd_idle_pct = 58;
        rcv_idle_pct = 25;
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        // noise: any code at all
        repeat ($urandom_range(4, 1)) send_kind(4'($urandom_range(15)));
      end else if (pick < 17) begin
        // fill the stack to one short of its depth or beyond, then flush it
        repeat ($urandom_range(STACK_DEPTH + 3, STACK_DEPTH - 1)) begin
          send_kind(STACKING_OPS[$urandom_range(3)]);
        end
        send_kind(($urandom_range(3) == 0) ? K_CLOSE : K_END);
      end else begin
        // well-formed expression with random brackets and signs
        n_operands = $urandom_range(6, 1);
        open_count = 0;
        for (int j = 0; j < n_operands; j++) begin
          if ($urandom_range(3) == 0) begin
            send_kind(K_OPEN);
            open_count++;
          end
          if ($urandom_range(4) == 0) send_kind(K_MINUS);
          send_operand();
          if (open_count > 0 && $urandom_range(2) == 0) begin
            send_kind(K_CLOSE);
            open_count--;
          end
          if (j < n_operands - 1) send_kind(BINARY_OPS[$urandom_range(6)]);
        end
        // brackets are mostly closed; a few are left for the end mark to report
        while (open_count > 0 && $urandom_range(5) != 0) begin
          send_kind(K_CLOSE);
          open_count--;
        end
        if ($urandom_range(9) == 0) send_kind(K_CLOSE);
        if ($urandom_range(9) != 0) send_kind(K_END);
      end
    end
    in_valid_i <= 1'b0;

    // drain, then leave room for a token still popping without a result
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (STACK_DEPTH + 4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** infix_to_postfix_converter_unit: PASSED **");
    end else begin
      $display("** infix_to_postfix_converter_unit: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("** infix_to_postfix_converter_unit: FAILED **");
    $finish;
  end

endmodule
